### hw/rtl/xcr_pkg.sv
// Shared types and constants for the XMODEM-CRC receiver.
`default_nettype none
package xcr_pkg;
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_POLL   = 2'd1;
  localparam logic [1:0] OP_VERIFY = 2'd2;

  localparam logic [2:0] K_SEND    = 3'd0;
  localparam logic [2:0] K_ERASE   = 3'd1;
  localparam logic [2:0] K_STAGE   = 3'd2;
  localparam logic [2:0] K_PROGRAM = 3'd3;
  localparam logic [2:0] K_RECONF  = 3'd4;

  localparam logic [7:0] HDR_MARK = 8'h53;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] TX_READY = 8'h43;
  localparam logic [7:0] TX_ACK   = 8'h06;
  localparam logic [7:0] TX_NAK   = 8'h15;
  localparam logic [7:0] SEQ_OK   = 8'hFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [20:0] MAX_SECTORS = 21'h100000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [23:0] flash_address;
    logic [20:0] sector_count;
    logic [6:0]  data_offset;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/xcr_front.sv
// Front end: protocol state, classifies each request into up to two results.
`default_nettype none
module xcr_front #(
  parameter int SECTOR_BYTES = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] rx_byte,
  input  wire logic verify_ok,
  output xcr_pkg::result_t res0,
  output xcr_pkg::result_t res1,
  output logic [1:0] res_cnt
);
  import xcr_pkg::*;
  localparam int SB = $clog2(SECTOR_BYTES);

  logic header_done, header_valid, got_first_packet, awaiting_verify;
  logic [7:0] byte_position, sequence_number, sequence_complement, rc_hi;
  logic [15:0] running_crc;
  logic [31:0] image_size;
  logic [23:0] image_base;
  logic [25:0] expected_packets, accepted_packets;
  logic [32:0] pk_sum;
  logic [32:0] sc_full;
  logic [20:0] sc;
  logic [15:0] rx_crc;
  result_t r0, r1;

  assign pk_sum = {1'b0, image_size} + 33'd127;
  assign sc_full = {1'b0, image_size >> SB} + 33'd1;
  assign sc = (sc_full > {12'd0, MAX_SECTORS}) ? MAX_SECTORS : sc_full[20:0];
  assign rx_crc = {rc_hi, rx_byte};

  always_comb begin
    r0 = '0; r1 = '0; res_cnt = 2'd0;
    unique case (opcode)
      OP_BYTE: begin
        if (!awaiting_verify) begin
          if (!header_done) begin
            if (byte_position == 8'd7 && header_valid) begin
              r0.kind = K_ERASE; r0.flash_address = {image_base[15:0], rx_byte};
              r0.sector_count = sc; res_cnt = 2'd1;
            end
          end else if (byte_position == 8'd0) begin
            if (rx_byte == EOT_BYTE) begin
              r0.kind = K_SEND; r0.tx_byte = TX_ACK; res_cnt = 2'd1;
              if (accepted_packets == expected_packets) begin
                r1.kind = K_RECONF; r1.flash_address = image_base; res_cnt = 2'd2;
              end
            end
          end else if (byte_position >= 8'd3 && byte_position < 8'd131) begin
            r0.kind = K_STAGE; r0.data_offset = 7'(byte_position - 8'd3);
            r0.data_byte = rx_byte; res_cnt = 2'd1;
          end else if (byte_position == 8'd132) begin
            res_cnt = 2'd1;
            if (rx_crc == running_crc && (sequence_number ^ sequence_complement) == SEQ_OK)
            begin
              r0.kind = K_PROGRAM;
              r0.flash_address = image_base + {accepted_packets[16:0], 7'd0};
            end else begin
              r0.kind = K_SEND; r0.tx_byte = TX_NAK;
            end
          end
        end
      end
      OP_POLL: begin
        if (!got_first_packet) begin
          r0.kind = K_SEND; r0.tx_byte = TX_READY; res_cnt = 2'd1;
        end
      end
      OP_VERIFY: begin
        if (awaiting_verify) begin
          r0.kind = K_SEND; r0.tx_byte = verify_ok ? TX_ACK : TX_NAK; res_cnt = 2'd1;
        end
      end
      default: ;
    endcase
    if (res_cnt == 2'd1) r0.last = 1'b1;
    if (res_cnt == 2'd2) r1.last = 1'b1;
    res0 = r0; res1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_done <= 1'b0; header_valid <= 1'b0; got_first_packet <= 1'b0;
      awaiting_verify <= 1'b0; byte_position <= '0; running_crc <= '0;
      sequence_number <= '0; sequence_complement <= '0; rc_hi <= '0;
      image_size <= '0; image_base <= '0; expected_packets <= '0;
      accepted_packets <= '0;
    end else if (in_fire) begin
      if (opcode == OP_BYTE && !awaiting_verify) begin
        if (!header_done) begin
          if (byte_position == 8'd0) begin
            header_valid <= (rx_byte == HDR_MARK); image_size <= '0; image_base <= '0;
          end else if (byte_position <= 8'd4) begin
            image_size <= {image_size[23:0], rx_byte};
          end else begin
            image_base <= {image_base[15:0], rx_byte};
          end
          if (byte_position < 8'd7) byte_position <= byte_position + 8'd1;
          else begin
            byte_position <= '0; header_done <= 1'b1;
            if (header_valid) expected_packets <= pk_sum[32:7];
          end
        end else if (byte_position == 8'd0) begin
          if (rx_byte == EOT_BYTE) accepted_packets <= '0;
          else begin
            running_crc <= '0; byte_position <= 8'd1;
          end
        end else begin
          if (byte_position != 8'd132) byte_position <= byte_position + 8'd1;
          if (byte_position == 8'd1) sequence_number <= rx_byte;
          else if (byte_position == 8'd2) sequence_complement <= rx_byte;
          else if (byte_position < 8'd131) running_crc <= crc_byte(running_crc, rx_byte);
          else if (byte_position == 8'd131) rc_hi <= rx_byte;
          else begin
            got_first_packet <= 1'b1; byte_position <= '0;
            if (rx_crc == running_crc &&
                (sequence_number ^ sequence_complement) == SEQ_OK)
              awaiting_verify <= 1'b1;
          end
        end
      end else if (opcode == OP_VERIFY && awaiting_verify) begin
        awaiting_verify <= 1'b0;
        if (verify_ok) accepted_packets <= accepted_packets + 26'd1;
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/xcr_queue.sv
// Result queue between front end and output port; takes up to two entries per push.
`default_nettype none
module xcr_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1:0] push_cnt,
  input  xcr_pkg::result_t push0,
  input  xcr_pkg::result_t push1,
  output logic room,
  output logic out_valid,
  output xcr_pkg::result_t out_res,
  input  wire logic pop
);
  import xcr_pkg::*;
  result_t mem [4];
  logic [1:0] rd, wr;
  logic [2:0] count;
  logic do_pop;

  assign do_pop = pop && out_valid;
  assign out_valid = count != 3'd0;
  assign out_res = mem[rd];
  assign room = count <= 3'd2;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr] <= push0;
    if (push_cnt == 2'd2) mem[wr + 2'd1] <= push1;
    if (rst) begin
      rd <= '0; wr <= '0; count <= '0;
    end else begin
      wr <= wr + push_cnt;
      if (do_pop) rd <= rd + 2'd1;
      count <= count + {1'b0, push_cnt} - {2'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/xmodem_crc_receiver_top.sv
// Top level of the XMODEM-CRC receiver.
`default_nettype none
// XMODEM-CRC receiver: one request (UART byte, poll tick, verify report) is
// taken per cycle and produces zero to two result items, drained one per
// cycle while out_ready is high from a four-entry queue. The front end does
// the header parse, the one-byte CRC-16 update and packet framing for each
// request as it is taken; in_ready drops only while the queue holds more
// than two results, so the sustained rate is one request per cycle when the
// consumer keeps up. The last flag marks the final result of a request.
module xmodem_crc_receiver_top #(
  parameter int SECTOR_BYTES = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] rx_byte,
  input  wire logic verify_ok,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [2:0] kind,
  output logic [7:0] tx_byte,
  output logic [23:0] flash_address,
  output logic [20:0] sector_count,
  output logic [6:0] data_offset,
  output logic [7:0] data_byte,
  output logic last
);
  import xcr_pkg::*;
  result_t r0, r1, q;
  logic [1:0] cnt;
  logic fire;

  assign fire = in_valid && in_ready;

  xcr_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
    .clk, .rst, .in_fire(fire), .opcode, .rx_byte, .verify_ok,
    .res0(r0), .res1(r1), .res_cnt(cnt)
  );

  xcr_queue u_q (
    .clk, .rst, .push_cnt(fire ? cnt : 2'd0), .push0(r0), .push1(r1),
    .room(in_ready), .out_valid, .out_res(q), .pop(out_ready)
  );

  assign kind = q.kind;
  assign tx_byte = q.tx_byte;
  assign flash_address = q.flash_address;
  assign sector_count = q.sector_count;
  assign data_offset = q.data_offset;
  assign data_byte = q.data_byte;
  assign last = q.last;

`ifndef SYNTH
  a_reconf_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_RECONF |-> last) else $error("reconfigure not last");
  a_stage_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_STAGE |-> last) else $error("stage not last");
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid) else $error("stalled with empty queue");
`endif
endmodule
`default_nettype wire

### test/xmodem_crc_receiver_checker.sv
// Checker for the XMODEM-CRC receiver: predicts result items and compares them.
module xmodem_crc_receiver_checker #(
  parameter int SECTOR_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  input  logic        verify_ok,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  tx_byte,
  input  logic [23:0] flash_address,
  input  logic [20:0] sector_count,
  input  logic [6:0]  data_offset,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  import xcr_pkg::*;

  result_t expected_results[$];

  logic        hdr_seen, hdr_good, first_pkt_seen, wait_verify;
  logic [7:0]  pos, seq_no, seq_inv;
  logic [15:0] crc_acc, crc_rx;
  logic [31:0] img_size;
  logic [23:0] img_base;
  logic [25:0] pkt_target, pkt_done;

  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    repeat (8) v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
    return v;
  endfunction

  function automatic result_t mk(input logic [2:0] k, input logic [7:0] tx,
                                 input logic [23:0] a, input logic [20:0] sc,
                                 input logic [6:0] off, input logic [7:0] d);
    result_t r;
    r.kind = k; r.tx_byte = tx; r.flash_address = a; r.sector_count = sc;
    r.data_offset = off; r.data_byte = d; r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_request(input logic [1:0] op, input logic [7:0] b, input logic ok);
    result_t res[$];
    longint  sc;
    longint  addr;
    if (op == OP_BYTE && !wait_verify) begin
      if (!hdr_seen) begin
        if (pos == 0) begin
          hdr_good = (b == HDR_MARK);
          img_size = '0;
          img_base = '0;
        end else if (pos <= 4) img_size = {img_size[23:0], b};
        else img_base = {img_base[15:0], b};
        if (pos < 7) pos = pos + 1;
        else begin
          pos = 0;
          hdr_seen = 1'b1;
          if (hdr_good) begin
            pkt_target = 26'((longint'(img_size) + 127) / 128);
            sc = longint'(img_size) / SECTOR_BYTES + 1;
            if (sc > MAX_SECTORS) sc = MAX_SECTORS;
            res.push_back(mk(K_ERASE, 8'h00, img_base, 21'(sc), 7'd0, 8'h00));
          end
        end
      end else if (pos == 0) begin
        if (b == EOT_BYTE) begin
          res.push_back(mk(K_SEND, TX_ACK, 24'd0, 21'd0, 7'd0, 8'h00));
          if (pkt_done == pkt_target)
            res.push_back(mk(K_RECONF, 8'h00, img_base, 21'd0, 7'd0, 8'h00));
          pkt_done = '0;
        end else begin
          crc_acc = '0;
          pos = 1;
        end
      end else begin
        if (pos == 1) seq_no = b;
        else if (pos == 2) seq_inv = b;
        else if (pos < 131) begin
          crc_acc = crc16_next(crc_acc, b);
          res.push_back(mk(K_STAGE, 8'h00, 24'd0, 21'd0, 7'(pos - 3), b));
        end else if (pos == 131) crc_rx = {b, 8'h00};
        if (pos == 132) begin
          crc_rx[7:0] = b;
          first_pkt_seen = 1'b1;
          pos = 0;
          if (crc_rx == crc_acc && (seq_no ^ seq_inv) == SEQ_OK) begin
            addr = longint'(img_base) + longint'(pkt_done) * 128;
            res.push_back(mk(K_PROGRAM, 8'h00, 24'(addr), 21'd0, 7'd0, 8'h00));
            wait_verify = 1'b1;
          end else res.push_back(mk(K_SEND, TX_NAK, 24'd0, 21'd0, 7'd0, 8'h00));
        end else pos = pos + 1;
      end
    end else if (op == OP_POLL && !first_pkt_seen) begin
      res.push_back(mk(K_SEND, TX_READY, 24'd0, 21'd0, 7'd0, 8'h00));
    end else if (op == OP_VERIFY && wait_verify) begin
      wait_verify = 1'b0;
      if (ok) begin
        pkt_done = pkt_done + 1;
        res.push_back(mk(K_SEND, TX_ACK, 24'd0, 21'd0, 7'd0, 8'h00));
      end else res.push_back(mk(K_SEND, TX_NAK, 24'd0, 21'd0, 7'd0, 8'h00));
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      hdr_good = 0; first_pkt_seen = 0; wait_verify = 0;
      pos = 0; seq_no = 0; seq_inv = 0; crc_acc = 0; crc_rx = 0;
      img_size = 0; img_base = 0; pkt_target = 0; pkt_done = 0;
      hdr_seen = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{kind, tx_byte, flash_address, sector_count, data_offset, data_byte, last};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
              got.flash_address !== want.flash_address ||
              got.sector_count !== want.sector_count ||
              got.data_offset !== want.data_offset ||
              got.data_byte !== want.data_byte || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (in_valid && in_ready) predict_request(opcode, rx_byte, verify_ok);
    end
    pending = expected_results.size();
  end
endmodule

### test/xmodem_crc_receiver_top_tb.sv
// Testbench top for the XMODEM-CRC receiver: stimulus, back-pressure and verdict.
module xmodem_crc_receiver_top_tb;
  import xcr_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [7:0]  rx_byte = '0;
  logic        verify_ok = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  kind;
  logic [7:0]  tx_byte;
  logic [23:0] flash_address;
  logic [20:0] sector_count;
  logic [6:0]  data_offset;
  logic [7:0]  data_byte;
  logic        last;
  int          fail_count;
  int          pending;
  int          results_seen = 0;
  bit          stim_done = 0;

  localparam logic [1:0] OP_IGNORED = 2'd3;

  xmodem_crc_receiver_top dut (.*);
  xmodem_crc_receiver_checker chk (.*);

  always #10 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stimulus-side CRC, needed to build packets that pass the check.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    repeat (8) v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
    return v;
  endfunction

  // One request; valid holds until accepted. Called right after a falling edge.
  task automatic send_req(input logic [1:0] op, input logic [7:0] b, input logic ok);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1; opcode = op; rx_byte = b; verify_ok = ok;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Background noise that must not disturb framing: polls and unknown opcodes.
  task automatic maybe_noise();
    if ($urandom_range(0, 39) == 0) send_req(OP_POLL, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 59) == 0) send_req(OP_IGNORED, 8'($urandom), 1'($urandom));
  endtask

  // One 133-byte packet; bad_seq or bad_crc break the check on purpose.
  task automatic send_packet(input logic [7:0] seq, input bit bad_seq, input bit bad_crc);
    logic [7:0]  head, d;
    logic [15:0] crc;
    int          style;
    head = 8'($urandom);
    if (head == EOT_BYTE) head = 8'h01;
    crc = '0;
    style = $urandom_range(0, 3);
    send_req(OP_BYTE, head, 0);
    send_req(OP_BYTE, seq, 0);
    send_req(OP_BYTE, bad_seq ? seq : ~seq, 0);
    for (int i = 0; i < 128; i++) begin
      if (style == 0) d = (i % 2) ? 8'hFF : 8'h00;
      else d = 8'($urandom);
      crc = crc_step(crc, d);
      send_req(OP_BYTE, d, 0);
      maybe_noise();
    end
    if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    send_req(OP_BYTE, crc[15:8], 0);
    send_req(OP_BYTE, crc[7:0], 0);
  endtask

  // Sink: random stalls, plus one long hold-off once output traffic is flowing.
  initial begin
    int  hold;
    bit  held;
    held = 0;
    @(negedge clk);
    while (1) begin
      if (!held && results_seen >= 40) begin
        held = 1;
        out_ready = 0;
        repeat (300) @(negedge clk);
      end
      hold = gap_len();
      if (hold > 0) begin
        out_ready = 0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1;
      @(negedge clk);
    end
  end

  always @(posedge clk) if (!rst && out_valid && out_ready) results_seen <= results_seen + 1;

  initial begin
    logic [31:0] img_size;
    logic [23:0] img_base;
    logic [7:0]  seq;
    int          sel, npk;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed opening: polls before the header, stray verify, unknown opcode.
    send_req(OP_POLL, 8'h00, 0);
    send_req(OP_VERIFY, 8'hFF, 1);
    send_req(OP_IGNORED, 8'hFF, 1);
    send_req(OP_POLL, 8'hFF, 1);

    // Header: usually well-formed, sometimes a bad marker; sizes span the extremes.
    sel = $urandom_range(0, 5);
    img_size = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 384);
    img_base = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom);
    send_req(OP_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom | 1) ^ HDR_MARK : HDR_MARK, 0);
    for (int i = 3; i >= 0; i--) send_req(OP_BYTE, img_size[i*8 +: 8], 0);
    for (int i = 2; i >= 0; i--) send_req(OP_BYTE, img_base[i*8 +: 8], 0);
    send_req(OP_POLL, 8'h00, 0);

    // Two transfers, each ending in EOT; three packets in all, some broken.
    seq = 8'd1;
    for (int r = 0; r < 2; r++) begin
      npk = (r == 0) ? 2 : 1;
      for (int p = 0; p < npk; p++) begin
        sel = $urandom_range(0, 5);
        send_packet(seq, sel == 4, sel == 5);
        if (sel < 4) begin
          // Block is waiting for verify: bytes are ignored here.
          if ($urandom_range(0, 1)) send_req(OP_BYTE, 8'($urandom), 0);
          send_req(OP_POLL, 8'h00, 0);
          send_req(OP_VERIFY, 8'h00, $urandom_range(0, 4) != 0);
          seq++;
        end else send_req(OP_VERIFY, 8'h00, 1);
      end
      send_req(OP_BYTE, EOT_BYTE, 0);
    end
    in_valid = 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("xmodem_crc_receiver_top_tb OK");
    end else begin
      $display("xmodem_crc_receiver_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("xmodem_crc_receiver_top_tb NOT OK");
    $finish;
  end
endmodule
